// ----- sv/shw_pkg.sv -----
// ----------------------------------------------------------------------------
// shw_pkg
// Shared types and constants for the sleep hang watchdog.
// ----------------------------------------------------------------------------
package shw_pkg;

    localparam int unsigned MODE_BITS    = 3;
    localparam int unsigned TIMEOUT_BITS = 16;
    localparam int unsigned KIND_BITS    = 2;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_DISABLED = 16'hFFFF;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_DEFAULT  = 16'h0000;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK          = 3'd0,
        MODE_SUSPEND_START = 3'd1,
        MODE_SUSPEND       = 3'd2,
        MODE_RESUME        = 3'd3,
        MODE_RESUME_DONE   = 3'd4,
        MODE_RESET_TRACK   = 3'd5
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE    = 2'd0,
        KIND_SUSPEND = 2'd1,
        KIND_RESUME  = 2'd2
    } kind_t;

    // status flags of one result, highest bit first in the packed word
    typedef struct packed {
        kind_t hang_kind;
        logic  hang_detected;
        logic  report_valid;
        logic  timeout_seen;
    } flags_t;

endpackage

// ----- sv/shw_core.sv -----
// ----------------------------------------------------------------------------
// shw_core
// Tracking state and combinational event decode for the sleep hang watchdog.
// ----------------------------------------------------------------------------
module shw_core #(
    parameter int unsigned COUNT_BITS = 31
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  ev_accept,
    input  shw_pkg::mode_t                        ev_mode,
    input  logic [shw_pkg::TIMEOUT_BITS-1:0]      ev_host_timeout,
    input  logic [shw_pkg::TIMEOUT_BITS-1:0]      default_timeout,
    output logic [COUNT_BITS-1:0]                 res_count,
    output shw_pkg::flags_t                       res_flags
);

    logic [COUNT_BITS-1:0]               transitions_reg, transitions_next;
    logic                                timed_out_reg, timed_out_next;
    logic [shw_pkg::TIMEOUT_BITS-1:0]    armed_reg, armed_next;
    logic [shw_pkg::TIMEOUT_BITS-1:0]    remaining_reg, remaining_next;
    logic                                running_reg, running_next;
    shw_pkg::kind_t                      pending_reg, pending_next;

    logic [COUNT_BITS-1:0]               count_inc;
    logic [shw_pkg::TIMEOUT_BITS-1:0]    chosen_timeout;
    logic                                report;
    logic                                hang;
    shw_pkg::kind_t                      kind;

    // saturating transition count
    assign count_inc = (&transitions_reg) ? transitions_reg
                                          : transitions_reg + COUNT_BITS'(1);

    assign chosen_timeout = (ev_host_timeout == shw_pkg::TIMEOUT_DEFAULT) ?
                            default_timeout : ev_host_timeout;

    always_comb begin
        transitions_next = transitions_reg;
        timed_out_next   = timed_out_reg;
        armed_next       = armed_reg;
        remaining_next   = remaining_reg;
        running_next     = running_reg;
        pending_next     = pending_reg;
        report           = 1'b0;
        hang             = 1'b0;
        kind             = shw_pkg::KIND_NONE;
        case (ev_mode)
            shw_pkg::MODE_TICK: begin
                if (running_reg) begin
                    if (remaining_reg <= shw_pkg::TIMEOUT_BITS'(1)) begin
                        remaining_next = '0;
                        running_next   = 1'b0;
                        timed_out_next = 1'b1;
                        if (pending_reg != shw_pkg::KIND_NONE) begin
                            hang = 1'b1;
                            kind = pending_reg;
                        end
                    end else begin
                        remaining_next = remaining_reg - shw_pkg::TIMEOUT_BITS'(1);
                    end
                end
            end
            shw_pkg::MODE_SUSPEND_START: begin
                transitions_next = '0;
                timed_out_next   = 1'b0;
                if (ev_host_timeout == shw_pkg::TIMEOUT_DISABLED) begin
                    armed_next = '0;
                end else begin
                    armed_next   = chosen_timeout;
                    pending_next = shw_pkg::KIND_SUSPEND;
                    if (!running_reg) begin
                        running_next   = 1'b1;
                        remaining_next = chosen_timeout;
                    end
                end
            end
            shw_pkg::MODE_SUSPEND: begin
                transitions_next = count_inc;
                running_next     = 1'b0;
            end
            shw_pkg::MODE_RESUME: begin
                transitions_next = count_inc;
                if (armed_reg != '0) begin
                    pending_next = shw_pkg::KIND_RESUME;
                    if (!running_reg) begin
                        running_next   = 1'b1;
                        remaining_next = armed_reg;
                    end
                end
            end
            shw_pkg::MODE_RESUME_DONE: begin
                armed_next   = '0;
                running_next = 1'b0;
                report       = 1'b1;
            end
            shw_pkg::MODE_RESET_TRACK: begin
                transitions_next = '0;
                timed_out_next   = 1'b0;
                armed_next       = '0;
                pending_next     = shw_pkg::KIND_NONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transitions_reg <= '0;
            timed_out_reg   <= 1'b0;
            armed_reg       <= '0;
            remaining_reg   <= '0;
            running_reg     <= 1'b0;
            pending_reg     <= shw_pkg::KIND_NONE;
        end else if (ev_accept) begin
            transitions_reg <= transitions_next;
            timed_out_reg   <= timed_out_next;
            armed_reg       <= armed_next;
            remaining_reg   <= remaining_next;
            running_reg     <= running_next;
            pending_reg     <= pending_next;
        end
    end

    assign res_count               = transitions_next;
    assign res_flags.timeout_seen  = timed_out_next;
    assign res_flags.report_valid  = report;
    assign res_flags.hang_detected = hang;
    assign res_flags.hang_kind     = kind;

`ifndef NO_ASSERTIONS
    a_suspend_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_accept && ev_mode == shw_pkg::MODE_SUSPEND |=> !running_reg)
        else $error("timer still running after suspend");
    a_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_accept && ev_mode == shw_pkg::MODE_TICK && running_reg &&
        remaining_reg <= shw_pkg::TIMEOUT_BITS'(1) |=> timed_out_reg && !running_reg)
        else $error("timer expiry not recorded");
    a_hang_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        hang |-> running_reg && pending_reg != shw_pkg::KIND_NONE)
        else $error("hang without running timer or hang kind");
    a_done_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_accept && ev_mode == shw_pkg::MODE_RESUME_DONE |=> armed_reg == '0)
        else $error("timeout still armed after resume complete");
`endif

endmodule

// ----- sv/shw_out_reg.sv -----
// ----------------------------------------------------------------------------
// shw_out_reg
// Result register with valid flag; takes a new result while the held one
// is being drained.
// ----------------------------------------------------------------------------
module shw_out_reg #(
    parameter int unsigned WIDTH = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/sleep_hang_watchdog_unit.sv -----
// result: registered; an accepted request's result is on m_tdata in the next cycle
// throughput: one request per cycle unless a held result stalls on m_tready;
// the tracking state and the countdown step update in the same cycle the request is accepted
// reset: aresetn low clears the tracking state, the timer, the default
// timeout register and the result valid flag
// ----------------------------------------------------------------------------
// sleep_hang_watchdog_unit
// Suspend and resume hang watchdog with a millisecond countdown timer.
// ----------------------------------------------------------------------------
module sleep_hang_watchdog_unit #(
    parameter int unsigned COUNT_BITS = 31
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [shw_pkg::TIMEOUT_BITS-1:0]        cfg_data,      // default_timeout_ms
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [shw_pkg::TIMEOUT_BITS-1:0]        s_tdata,       // host_timeout_ms
    input  logic [shw_pkg::MODE_BITS-1:0]           s_tuser,       // mode
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // transition_count, timeout_seen, report_valid, hang_detected, hang_kind
    output logic [((COUNT_BITS + 5 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int unsigned RES_BITS = COUNT_BITS + $bits(shw_pkg::flags_t);
    localparam int unsigned OUT_BITS = ((RES_BITS + 7) / 8) * 8;

    logic [shw_pkg::TIMEOUT_BITS-1:0] default_timeout_reg;
    logic                             accept;
    logic [COUNT_BITS-1:0]            res_count;
    shw_pkg::flags_t                  res_flags;
    logic [OUT_BITS-1:0]              res_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_timeout_reg <= '0;
        end else if (cfg_valid) begin
            default_timeout_reg <= cfg_data;
        end
    end

    assign accept = s_tvalid && s_tready;

    shw_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ev_accept       (accept),
        .ev_mode         (shw_pkg::mode_t'(s_tuser)),
        .ev_host_timeout (s_tdata),
        .default_timeout (default_timeout_reg),
        .res_count       (res_count),
        .res_flags       (res_flags)
    );

    assign res_word = OUT_BITS'({res_flags, res_count});

    shw_out_reg #(
        .WIDTH (OUT_BITS)
    ) u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives suspend, resume and tick requests into the sleep hang watchdog and
// checks every status word against a cycle-free prediction of the watchdog.
// The run covers a directed pass over every event kind, a partial countdown
// from the longest timeout, random suspend and resume sequences under several
// default timeouts, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned COUNT_BITS = 31;
    localparam int unsigned OUT_BITS   = ((COUNT_BITS + 5 + 7) / 8) * 8;

    localparam logic [shw_pkg::MODE_BITS-1:0]    MODE_SPARE_6    = 3'd6;
    localparam logic [shw_pkg::MODE_BITS-1:0]    MODE_SPARE_7    = 3'd7;
    localparam logic [shw_pkg::TIMEOUT_BITS-1:0] TIMEOUT_LONGEST = 16'hFFFE;
    localparam int unsigned                      LONGEST_TICKS   = 40;

    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_EVENTS  = 200;

    typedef struct packed {
        shw_pkg::flags_t       flags;
        logic [COUNT_BITS-1:0] count;
    } status_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [shw_pkg::TIMEOUT_BITS-1:0] cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [shw_pkg::TIMEOUT_BITS-1:0] s_tdata   = '0;
    logic [shw_pkg::MODE_BITS-1:0]    s_tuser   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [OUT_BITS-1:0]              m_tdata;

    // predicted watchdog state
    logic [COUNT_BITS-1:0]            trans_cnt    = '0;
    logic                             seen_timeout = 1'b0;
    logic [shw_pkg::TIMEOUT_BITS-1:0] armed_ms     = '0;
    logic [shw_pkg::TIMEOUT_BITS-1:0] left_ms      = '0;
    logic                             running      = 1'b0;
    shw_pkg::kind_t                   pend_kind    = shw_pkg::KIND_NONE;
    logic [shw_pkg::TIMEOUT_BITS-1:0] dflt_ms      = '0;

    status_t status_backlog[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_req   = 0;

    int fault_count   = 0;
    int events_sent   = 0;
    int results_seen  = 0;
    int hangs_seen    = 0;
    int reports_seen  = 0;
    int cfg_writes    = 0;

    sleep_hang_watchdog_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic void start_countdown(logic [shw_pkg::TIMEOUT_BITS-1:0] ms);
        if (!running) begin
            running = 1'b1;
            left_ms = ms;
        end
    endfunction

    function automatic void count_transition();
        if (trans_cnt != '1) begin
            trans_cnt = trans_cnt + 1'b1;
        end
    endfunction

    function automatic status_t advance_watchdog(
        logic [shw_pkg::MODE_BITS-1:0]    mode,
        logic [shw_pkg::TIMEOUT_BITS-1:0] host_ms
    );
        status_t st;
        logic [shw_pkg::TIMEOUT_BITS-1:0] ms;
        st = '0;
        ms = host_ms;
        case (mode)
            shw_pkg::MODE_TICK: begin
                if (running) begin
                    if (left_ms <= 16'd1) begin
                        left_ms = '0;
                        running = 1'b0;
                        seen_timeout = 1'b1;
                        if (pend_kind != shw_pkg::KIND_NONE) begin
                            st.flags.hang_detected = 1'b1;
                            st.flags.hang_kind = pend_kind;
                        end
                    end else begin
                        left_ms = left_ms - 1'b1;
                    end
                end
            end
            shw_pkg::MODE_SUSPEND_START: begin
                trans_cnt = '0;
                seen_timeout = 1'b0;
                if (host_ms == shw_pkg::TIMEOUT_DISABLED) begin
                    armed_ms = '0;
                end else begin
                    if (host_ms == shw_pkg::TIMEOUT_DEFAULT) begin
                        ms = dflt_ms;
                    end
                    armed_ms = ms;
                    pend_kind = shw_pkg::KIND_SUSPEND;
                    start_countdown(ms);
                end
            end
            shw_pkg::MODE_SUSPEND: begin
                count_transition();
                running = 1'b0;
            end
            shw_pkg::MODE_RESUME: begin
                count_transition();
                if (armed_ms != '0) begin
                    pend_kind = shw_pkg::KIND_RESUME;
                    start_countdown(armed_ms);
                end
            end
            shw_pkg::MODE_RESUME_DONE: begin
                armed_ms = '0;
                running = 1'b0;
                st.flags.report_valid = 1'b1;
            end
            shw_pkg::MODE_RESET_TRACK: begin
                trans_cnt = '0;
                seen_timeout = 1'b0;
                armed_ms = '0;
                pend_kind = shw_pkg::KIND_NONE;
            end
            default: ;
        endcase
        st.count = trans_cnt;
        st.flags.timeout_seen = seen_timeout;
        return st;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_gap();
        if (!tx_idle_on || $urandom_range(0, 99) < 55) begin
            return 0;
        end
        return pick_len();
    endfunction

    function automatic logic [shw_pkg::TIMEOUT_BITS-1:0] pick_host_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return shw_pkg::TIMEOUT_DEFAULT;
        end else if (r < 35) begin
            return shw_pkg::TIMEOUT_DISABLED;
        end else if (r < 90) begin
            return shw_pkg::TIMEOUT_BITS'($urandom_range(1, 12));
        end
        return shw_pkg::TIMEOUT_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [shw_pkg::TIMEOUT_BITS-1:0] pick_any_timeout();
        return shw_pkg::TIMEOUT_BITS'($urandom_range(0, 65535));
    endfunction

    task automatic send_event(input logic [shw_pkg::MODE_BITS-1:0] mode,
                              input logic [shw_pkg::TIMEOUT_BITS-1:0] host_ms);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= host_ms;
        do @(posedge aclk); while (!s_tready);
        status_backlog.push_back(advance_watchdog(mode, host_ms));
        events_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_event(shw_pkg::MODE_TICK, pick_any_timeout());
    endtask

    task automatic send_noise();
        send_event(shw_pkg::MODE_BITS'($urandom_range(0, 7)), pick_any_timeout());
    endtask

    // every request gives one result, so an empty backlog means the block is idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (status_backlog.size() != 0) @(posedge aclk);
    endtask

    task automatic write_default_timeout(input logic [shw_pkg::TIMEOUT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dflt_ms = value;
        cfg_writes++;
    endtask

    task automatic run_sleep_cycle();
        send_ticks($urandom_range(0, 4));
        send_event(shw_pkg::MODE_SUSPEND_START, pick_host_timeout());
        send_ticks($urandom_range(0, 6));
        if ($urandom_range(0, 9) < 8) begin
            send_event(shw_pkg::MODE_SUSPEND, pick_any_timeout());
        end
        send_ticks($urandom_range(0, 8));
        send_event(shw_pkg::MODE_RESUME, pick_any_timeout());
        send_ticks($urandom_range(0, 12));
        if ($urandom_range(0, 9) < 9) begin
            send_event(shw_pkg::MODE_RESUME_DONE, pick_any_timeout());
        end
        if ($urandom_range(0, 9) == 0) begin
            send_event(shw_pkg::MODE_RESET_TRACK, pick_any_timeout());
        end
    endtask

    task automatic test_directed_events();
        write_default_timeout(16'd0);
        send_event(shw_pkg::MODE_TICK, 16'h0000);
        send_event(MODE_SPARE_6, 16'hFFFF);
        send_event(MODE_SPARE_7, 16'h0000);
        send_event(shw_pkg::MODE_RESUME, 16'hFFFF);
        // default timeout of zero expires on the next tick
        send_event(shw_pkg::MODE_SUSPEND_START, shw_pkg::TIMEOUT_DEFAULT);
        send_event(shw_pkg::MODE_TICK, 16'hFFFF);
        send_event(shw_pkg::MODE_RESUME_DONE, 16'h5A5A);
        send_event(shw_pkg::MODE_SUSPEND_START, shw_pkg::TIMEOUT_DISABLED);
        send_event(shw_pkg::MODE_TICK, 16'hA5A5);
        // suspend stops the timer, resume rearms it with a resume hang kind
        send_event(shw_pkg::MODE_SUSPEND_START, 16'd3);
        send_event(shw_pkg::MODE_SUSPEND, 16'hFFFF);
        send_event(shw_pkg::MODE_RESUME, 16'h0000);
        send_event(shw_pkg::MODE_RESUME, 16'h1234);
        send_ticks(3);
        // disabled request leaves a running timer alone
        send_event(shw_pkg::MODE_SUSPEND_START, 16'd2);
        send_event(shw_pkg::MODE_SUSPEND_START, shw_pkg::TIMEOUT_DISABLED);
        send_ticks(2);
        // expiry with no hang kind only sets the sticky flag
        send_event(shw_pkg::MODE_SUSPEND_START, 16'd1);
        send_event(shw_pkg::MODE_RESET_TRACK, 16'hFFFF);
        send_event(shw_pkg::MODE_TICK, 16'h8001);
        send_event(shw_pkg::MODE_RESET_TRACK, 16'h0000);
        send_event(shw_pkg::MODE_RESUME_DONE, 16'hFFFF);
    endtask

    task automatic test_longest_timeout();
        settle_block();
        write_default_timeout(TIMEOUT_LONGEST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_event(shw_pkg::MODE_SUSPEND_START, shw_pkg::TIMEOUT_DEFAULT);
        send_ticks(LONGEST_TICKS);
        send_event(shw_pkg::MODE_RESUME_DONE, 16'h0000);
        settle_block();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int goal;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_block();
            case (phase)
                0: write_default_timeout(16'd1);
                1: write_default_timeout(16'd0);
                2: write_default_timeout(TIMEOUT_LONGEST);
                default: write_default_timeout(
                    shw_pkg::TIMEOUT_BITS'($urandom_range(0, 20)));
            endcase
            tx_idle_on = (phase % 4 != 1);
            rx_idle_on = (phase % 4 != 2) && (phase % 4 != 1);
            goal = events_sent + PHASE_EVENTS;
            while (events_sent < goal) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_noise();
                end else begin
                    run_sleep_cycle();
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        settle_block();
        hold_req = 200;
        tx_idle_on = 1'b0;
        repeat (20) run_sleep_cycle();
        settle_block();
        tx_idle_on = 1'b1;
    endtask

    initial begin : result_monitor
        status_t got;
        status_t want;
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = status_t'(m_tdata[COUNT_BITS+4:0]);
                results_seen++;
                if (status_backlog.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fault_count++;
                end else begin
                    want = status_backlog.pop_front();
                    if (want.flags.hang_detected) hangs_seen++;
                    if (want.flags.report_valid) reports_seen++;
                    if (got.count !== want.count) begin
                        $error("transition_count: expected %0d, got %0d",
                               want.count, got.count);
                        fault_count++;
                    end
                    if (got.flags.timeout_seen !== want.flags.timeout_seen) begin
                        $error("timeout_seen: expected %0d, got %0d",
                               want.flags.timeout_seen, got.flags.timeout_seen);
                        fault_count++;
                    end
                    if (got.flags.report_valid !== want.flags.report_valid) begin
                        $error("report_valid: expected %0d, got %0d",
                               want.flags.report_valid, got.flags.report_valid);
                        fault_count++;
                    end
                    if (got.flags.hang_detected !== want.flags.hang_detected) begin
                        $error("hang_detected: expected %0d, got %0d",
                               want.flags.hang_detected, got.flags.hang_detected);
                        fault_count++;
                    end
                    if (got.flags.hang_kind !== want.flags.hang_kind) begin
                        $error("hang_kind: expected %0d, got %0d",
                               want.flags.hang_kind, got.flags.hang_kind);
                        fault_count++;
                    end
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_len();
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_events();
        test_longest_timeout();
        test_random_sequences();
        test_output_backpressure();
        settle_block();
        repeat (4) @(posedge aclk);
        $display("testbench: %0d requests, %0d results, %0d hangs flagged, %0d resume reports",
                 events_sent, results_seen, hangs_seen, reports_seen);
        $display("testbench: %0d default timeout writes, from 0 up to 65534, with output stalls",
                 cfg_writes);
        if (fault_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
